[rtl/core/dtp_pkg.sv]
// Shared types, constants and the base ranking function for the DNA triplet packer.
package dtp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned JobBytes   = 4;

  localparam logic [7:0] TailMark   = 8'd255;
  localparam logic [2:0] EscapeRank = 3'd5;
  localparam logic [7:0] Radix      = 8'd6;

  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChN = 8'h4E;

  // One job: the output bytes caused by one input item.
  typedef struct packed {
    logic [JobBytes-1:0][7:0]      bytes;
    logic [$clog2(JobBytes)-1:0]   last_idx;
    logic                          seq_last;
  } job_t;

  function automatic logic [2:0] base_rank(input logic [7:0] ch);
    logic [2:0] r;
    unique case (ch)
      ChA:     r = 3'd0;
      ChC:     r = 3'd1;
      ChG:     r = 3'd2;
      ChT:     r = 3'd3;
      ChN:     r = 3'd4;
      default: r = EscapeRank;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/dtp_front.sv]
// Front end: holds pending characters, makes jobs of bytes per group or sequence end.
module dtp_front
  import dtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] symbol_i,
  input  logic       seq_last_i,
  output logic       full_o,
  input  logic       job_full_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [1:0] count_q, count_d;
  logic       accept;
  logic       group_done;
  logic [2:0] r0, r1, r2;
  logic       e0, e1, e2;
  logic [7:0] packed_byte;

  assign full_o     = job_full_i;
  assign accept     = push_i & ~job_full_i;
  assign group_done = count_q[1];   // a count of three also completes a group

  assign r0 = base_rank(first_q);
  assign r1 = base_rank(second_q);
  assign r2 = base_rank(symbol_i);
  assign e0 = (r0 == EscapeRank);
  assign e1 = (r1 == EscapeRank);
  assign e2 = (r2 == EscapeRank);

  // (r0*6 + r1)*6 + r2, at most 215
  assign packed_byte = 8'(((8'(r0) * Radix + 8'(r1)) * Radix) + 8'(r2));

  always_comb begin
    logic [1:0] k;
    k = '0;
    job_o = '0;
    job_o.seq_last = seq_last_i;
    if (group_done) begin
      job_o.bytes[0] = packed_byte;
      if (e0) begin
        k = k + 2'd1;
        job_o.bytes[k] = first_q;
      end
      if (e1) begin
        k = k + 2'd1;
        job_o.bytes[k] = second_q;
      end
      if (e2) begin
        k = k + 2'd1;
        job_o.bytes[k] = symbol_i;
      end
      job_o.last_idx = k;
    end else if (count_q == 2'd1) begin
      job_o.bytes[0] = TailMark;
      job_o.bytes[1] = first_q;
      job_o.bytes[2] = TailMark;
      job_o.bytes[3] = symbol_i;
      job_o.last_idx = 2'd3;
    end else begin
      job_o.bytes[0] = TailMark;
      job_o.bytes[1] = symbol_i;
      job_o.last_idx = 2'd1;
    end
  end

  assign job_valid_o = accept & (group_done | seq_last_i);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    count_d  = count_q;
    if (accept) begin
      if (group_done || seq_last_i) begin
        count_d = 2'd0;
      end else if (count_q == 2'd0) begin
        first_d = symbol_i;
        count_d = 2'd1;
      end else begin
        second_d = symbol_i;
        count_d  = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      count_q  <= '0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/core/dtp_queue.sv]
// Short job queue between front and back ends.
module dtp_queue
  import dtp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output job_t rd_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/dtp_back.sv]
// Back end: walks the bytes of the current job, one result per pop.
module dtp_back
  import dtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_empty_i,
  input  job_t       job_i,
  output logic       job_rd_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_end_o
);

  localparam int unsigned IdxW = $clog2(JobBytes);

  job_t            cur_q;
  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  logic            at_end, take, load;

  assign at_end = (idx_q == cur_q.last_idx);
  assign take   = valid_q & pop_i;
  assign load   = ~job_empty_i & (~valid_q | (take & at_end));

  assign job_rd_o     = load;
  assign empty_o      = ~valid_q;
  assign out_byte_o   = cur_q.bytes[idx_q];
  assign run_last_o   = at_end;
  assign stream_end_o = at_end & cur_q.seq_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (at_end) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

endmodule

[rtl/core/dna_triplet_packer_unit.sv]
// Top level of the DNA triplet packer: front end, job queue and back end.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   input    | push_i / full_o    | symbol_i[7:0], seq_last_i
//   result   | pop_i / empty_o    | out_byte_o[7:0], run_last_o, stream_end_o
//
// One item is accepted per cycle while the job queue has room. An item that
// causes results becomes a job of one to four bytes; the back end sends one
// byte per cycle while pop_i is high, so sustained rate is set by the bytes
// per job at the back. The first result of an item passes through the job
// queue and the back-end register before it reaches the result ports.
// Reset is asynchronous, active low, and empties pending state and queue.
// A stalled result side fills the four-entry queue and then raises full_o.
module dna_triplet_packer_unit
  import dtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] symbol_i,
  input  logic       seq_last_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_end_o
);

  job_t wr_job, rd_job;
  logic wr_valid, q_full, q_empty, q_rd;

  // classify characters, hold partial groups, build jobs
  dtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .symbol_i    (symbol_i),
    .seq_last_i  (seq_last_i),
    .full_o      (full_o),
    .job_full_i  (q_full),
    .job_valid_o (wr_valid),
    .job_o       (wr_job)
  );

  // decouples item intake from byte-by-byte draining
  dtp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_valid),
    .wr_data_i (wr_job),
    .full_o    (q_full),
    .rd_en_i   (q_rd),
    .rd_data_o (rd_job),
    .empty_o   (q_empty)
  );

  // serialize job bytes onto the result ports
  dtp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (q_empty),
    .job_i        (rd_job),
    .job_rd_o     (q_rd),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o)
  );

endmodule

[bench/tb_dna_triplet_packer_unit.sv]
// Testbench for the DNA triplet packer: directed, backpressure and random traffic.
`timescale 1ns / 100ps

module tb_dna_triplet_packer_unit;
  import dtp_pkg::*;

  // Cycles without any accepted item, on either side, before the run is declared hung.
  // The longest legal quiet stretch is the forced result hold-off (HoldCycles).
  localparam int unsigned HangLimit  = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned SettleCycles = 8;

  // One expected result item.
  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       stream_end;
  } out_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push_i;
  logic       full_o;
  logic [7:0] symbol_i;
  logic       seq_last_i;
  logic       empty_o;
  logic       pop_i;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       stream_end_o;

  // Predictor state: characters held while a triplet is being gathered.
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] held_count;

  out_item_t   expected_out[$];
  out_item_t   oldest;
  int unsigned mismatch_count;

  // Idle controls, changed per phase by the test tasks.
  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  bit          hold_req;

  dna_triplet_packer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .symbol_i    (symbol_i),
    .seq_last_i  (seq_last_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .stream_end_o(stream_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Base code: A C G T N map to 0..4, everything else is an escape.
  function automatic logic [2:0] symbol_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      ChA:     code = 3'd0;
      ChC:     code = 3'd1;
      ChG:     code = 3'd2;
      ChT:     code = 3'd3;
      ChN:     code = 3'd4;
      default: code = EscapeRank;
    endcase
    return code;
  endfunction

  function automatic out_item_t plain_out(input logic [7:0] v);
    out_item_t o;
    o.value      = v;
    o.run_last   = 1'b0;
    o.stream_end = 1'b0;
    return o;
  endfunction

  // Work out the result items caused by one accepted input item and queue them.
  function automatic void pack_symbol(input logic [7:0] sym, input logic last);
    out_item_t  burst[$];
    logic [2:0] c0, c1, c2;
    int         packed_val;
    if (held_count >= 2) begin
      // Triplet complete: packed byte, then raw escapes in order.
      c0 = symbol_code(held_first);
      c1 = symbol_code(held_second);
      c2 = symbol_code(sym);
      packed_val = (int'(c0) * int'(Radix) + int'(c1)) * int'(Radix) + int'(c2);
      burst = {burst, plain_out(packed_val[7:0])};
      if (c0 == EscapeRank) burst = {burst, plain_out(held_first)};
      if (c1 == EscapeRank) burst = {burst, plain_out(held_second)};
      if (c2 == EscapeRank) burst = {burst, plain_out(sym)};
      held_count = 2'd0;
    end else if (last) begin
      // Sequence ends short of a triplet: each leftover goes out as marker + raw.
      if (held_count >= 1) begin
        burst = {burst, plain_out(TailMark)};
        burst = {burst, plain_out(held_first)};
      end
      burst = {burst, plain_out(TailMark)};
      burst = {burst, plain_out(sym)};
      held_count = 2'd0;
    end else if (held_count == 0) begin
      held_first = sym;
      held_count = 2'd1;
    end else begin
      held_second = sym;
      held_count  = 2'd2;
    end

    if (burst.size() > 0) begin
      burst[burst.size()-1].run_last = 1'b1;
      if (last) burst[burst.size()-1].stream_end = 1'b1;
    end
    expected_out = {expected_out, burst};
    if (last) held_count = 2'd0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks popped results against the oldest expectation, then
  // predicts from the item accepted at the same edge. A result never comes
  // out in the cycle its item goes in, so this order is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with nothing expected", out_byte_o));
        end else begin
          oldest = expected_out.pop_front();
          if (out_byte_o !== oldest.value)
            report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                      out_byte_o, oldest.value));
          if (run_last_o !== oldest.run_last)
            report_mismatch($sformatf("run_last %b, want %b (byte 0x%02h)",
                                      run_last_o, oldest.run_last, oldest.value));
          if (stream_end_o !== oldest.stream_end)
            report_mismatch($sformatf("stream_end %b, want %b (byte 0x%02h)",
                                      stream_end_o, oldest.stream_end, oldest.value));
        end
      end
      if (push_i && !full_o) pack_symbol(symbol_i, seq_last_i);
    end
  end

  // Hang watchdog: counts cycles with no item moving on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < HangLimit) begin
      @(posedge clk_i);
      if (rst_ni && ((push_i && !full_o) || (pop_i && !empty_o))) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item moved for %0d cycles", HangLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, plus a long forced hold-off on request.
  initial begin
    pop_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      pop_i <= ($urandom_range(99) < pop_stall_pct) ? 1'b0 : 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after acceptance,
  // with push_i still high so a back-to-back item needs no second assignment.
  task automatic send_item(input logic [7:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i     <= 1'b1;
    symbol_i   <= sym;
    seq_last_i <= last;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  // Stop offering, then wait until every expected result has been popped.
  task automatic drain_results();
    push_i <= 1'b0;
    while (expected_out.size() > 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Mostly DNA bases, sometimes an arbitrary byte (escape, or a base by chance).
  function automatic logic [7:0] pick_symbol();
    logic [7:0] bases [5];
    bases = '{ChA, ChC, ChG, ChT, ChN};
    if ($urandom_range(9) < 7) return bases[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  // Whole sequences of random length; short ones exercise the tail cases.
  task automatic send_random_sequences(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(9, 1);
      for (int unsigned k = 0; k < len; k++) send_item(pick_symbol(), k == len - 1);
      sent += len;
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    // full triplet ending the sequence
    send_item(ChA, 1'b0); send_item(ChC, 1'b0); send_item(ChG, 1'b1);
    // triplet, then one leftover at the end
    send_item(ChT, 1'b0); send_item(ChN, 1'b0); send_item(ChA, 1'b0);
    send_item(ChC, 1'b1);
    // all three escaped, extreme byte values, raw 0xff is not a marker
    send_item(8'h00, 1'b0); send_item(8'hFF, 1'b0); send_item(8'h61, 1'b1);
    // escape in each position of the triplet
    send_item(8'h7F, 1'b0); send_item(ChC, 1'b0); send_item(ChG, 1'b0);
    send_item(ChA, 1'b0); send_item(8'h80, 1'b0); send_item(ChT, 1'b0);
    send_item(ChN, 1'b0); send_item(ChG, 1'b0); send_item(8'h01, 1'b1);
    // single-character sequence
    send_item(ChG, 1'b1);
    // two leftovers at the end, second one escaped
    send_item(ChT, 1'b0); send_item(8'hFF, 1'b1);
    // an all-N triplet ending the sequence
    send_item(ChN, 1'b0); send_item(ChN, 1'b0); send_item(ChN, 1'b1);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps pushing escape-heavy triplets,
  // so the job queue fills and full_o must stall the input.
  task automatic test_full_stall();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_req      = 1'b1;
    for (int k = 0; k < 24; k++) send_item(8'($urandom_range(255)), k == 23);
    drain_results();
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_random_sequences(100);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct = 62;
    pop_stall_pct = 0;
    send_random_sequences(100);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct = 0;
    pop_stall_pct = 62;
    send_random_sequences(100);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 32;
    pop_stall_pct = 32;
    send_random_sequences(100);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    push_i         = 1'b0;
    symbol_i       = 8'h00;
    seq_last_i     = 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    mismatch_count = 0;
    held_first     = 8'h00;
    held_second    = 8'h00;
    held_count     = 2'd0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_full_stall();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
